/* hw/rtl/tlsg_pkg.sv */
// Shared types, layout tables and constants for the tensor layout stride generator.
package tlsg_pkg;

  localparam int MAX_DIMS    = 5;
  localparam int NUM_UNR     = 2 * MAX_DIMS;
  localparam int NUM_STEPS   = NUM_UNR - 1;
  localparam int UNR_W       = $clog2(NUM_UNR);
  localparam int FMT_W       = 4;
  localparam int CNT_W       = 4;
  localparam int SIZE_W      = 12;
  localparam int STRIDE_W    = 60;
  localparam int DIM_W       = 3;
  localparam int BLK_W       = 4;
  localparam int NUM_FORMATS = 16;
  localparam int BLOCK_LEN   = 8;
  localparam int BLOCK_SHIFT = 3;
  localparam int LAY_PERM_W  = NUM_UNR * UNR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Dimension count per format; zero marks an unknown format.
  localparam logic [CNT_W-1:0] LAY_N [NUM_FORMATS] = '{
    4'd1, 4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4, 4'd4,
    4'd4, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // Bit d set: dimension d is split into blocks of BLOCK_LEN.
  localparam logic [MAX_DIMS-1:0] LAY_BLK8 [NUM_FORMATS] = '{
    5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00010, 5'b00000, 5'b00000, 5'b00011,
    5'b00001, 5'b00000, 5'b00110, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000
  };

  // Unrolled-part order, outermost first; entry j sits in nibble j.
  localparam logic [LAY_PERM_W-1:0] LAY_PERM [NUM_FORMATS] = '{
    40'h0000000010, 40'h0000003210, 40'h0076543210, 40'h0076541320,
    40'h0076543210, 40'h0000003210, 40'h0076543210, 40'h0076453210,
    40'h0076541320, 40'h9876543210, 40'h9867543210, 40'h0000000000,
    40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
  };

  // Classified request: part sizes right-aligned so the innermost part is at NUM_UNR-1.
  typedef struct packed {
    logic                                err;
    logic [DIM_W-1:0]                    n_last;
    logic [NUM_UNR-1:0][SIZE_W-1:0]      q;
    logic [MAX_DIMS-1:0][UNR_W-1:0]      pos_outer;
    logic [MAX_DIMS-1:0][UNR_W-1:0]      pos_inner;
    logic [MAX_DIMS-1:0]                 blk8;
  } item_t;

  typedef struct packed {
    item_t                               item;
    logic [NUM_UNR-1:0][STRIDE_W-1:0]    s;
  } stage_t;

endpackage

/* hw/rtl/tlsg_front.sv */
// Request classifier: layout lookup, count check and unrolled part ordering.
module tlsg_front (
  input  logic [tlsg_pkg::FMT_W-1:0]  format_i,
  input  logic [tlsg_pkg::CNT_W-1:0]  dim_count_i,
  input  logic [tlsg_pkg::SIZE_W-1:0] size_a_i,
  input  logic [tlsg_pkg::SIZE_W-1:0] size_b_i,
  input  logic [tlsg_pkg::SIZE_W-1:0] size_c_i,
  input  logic [tlsg_pkg::SIZE_W-1:0] size_d_i,
  input  logic [tlsg_pkg::SIZE_W-1:0] size_e_i,
  output tlsg_pkg::item_t             item_o
);

  logic [tlsg_pkg::CNT_W-1:0]      n;
  logic [tlsg_pkg::MAX_DIMS-1:0]   blk8;
  logic [tlsg_pkg::LAY_PERM_W-1:0] prm;
  logic [tlsg_pkg::UNR_W-1:0]      m;
  logic [tlsg_pkg::UNR_W-1:0]      off;
  logic [tlsg_pkg::UNR_W-1:0]      j;
  logic [tlsg_pkg::UNR_W-1:0]      u;
  logic [tlsg_pkg::SIZE_W-1:0]     val;
  logic [tlsg_pkg::SIZE_W-1:0]     sz [tlsg_pkg::MAX_DIMS];

  assign n    = tlsg_pkg::LAY_N[format_i];
  assign blk8 = tlsg_pkg::LAY_BLK8[format_i];
  assign prm  = tlsg_pkg::LAY_PERM[format_i];
  assign m    = tlsg_pkg::UNR_W'(n << 1);
  assign off  = tlsg_pkg::UNR_W'(tlsg_pkg::NUM_UNR) - m;

  assign sz[0] = size_a_i;
  assign sz[1] = size_b_i;
  assign sz[2] = size_c_i;
  assign sz[3] = size_d_i;
  assign sz[4] = size_e_i;

  always_comb begin
    item_o        = '0;
    item_o.err    = (n == '0) || (dim_count_i != n) ||
                    (n > tlsg_pkg::CNT_W'(tlsg_pkg::MAX_DIMS));
    item_o.n_last = item_o.err ? '0 : tlsg_pkg::DIM_W'(n - tlsg_pkg::CNT_W'(1));
    item_o.blk8   = blk8;
    j             = '0;
    u             = '0;
    val           = '0;
    for (int i = 0; i < tlsg_pkg::NUM_UNR; i++) begin
      if (tlsg_pkg::UNR_W'(i) >= off) begin
        j   = tlsg_pkg::UNR_W'(i) - off;
        u   = prm[j*tlsg_pkg::UNR_W +: tlsg_pkg::UNR_W];
        val = '0;
        for (int d = 0; d < tlsg_pkg::MAX_DIMS; d++) begin
          if ((u == tlsg_pkg::UNR_W'(d)) &&
              (tlsg_pkg::UNR_W'(d) < tlsg_pkg::UNR_W'(n))) begin
            val = blk8[d] ? (sz[d] >> tlsg_pkg::BLOCK_SHIFT) : sz[d];
            item_o.pos_outer[d] = tlsg_pkg::UNR_W'(i);
          end
          if (u == (tlsg_pkg::UNR_W'(n) + tlsg_pkg::UNR_W'(d))) begin
            val = blk8[d] ? tlsg_pkg::SIZE_W'(tlsg_pkg::BLOCK_LEN) : tlsg_pkg::SIZE_W'(1);
            item_o.pos_inner[d] = tlsg_pkg::UNR_W'(i);
          end
        end
        item_o.q[i] = val;
      end
    end
  end

endmodule

/* hw/rtl/tlsg_fifo.sv */
// Two-entry request queue between the classifier and the stride back end.
module tlsg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tlsg_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tlsg_pkg::item_t item_o
);

  logic [tlsg_pkg::QPTR_W-1:0] wr_q, wr_d;
  logic [tlsg_pkg::QPTR_W-1:0] rd_q, rd_d;
  logic [tlsg_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  tlsg_pkg::item_t             mem_q [tlsg_pkg::QUEUE_DEPTH];
  logic                        push_ok;
  logic                        pop_ok;

  assign full_o  = (cnt_q == tlsg_pkg::QCNT_W'(tlsg_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_ok ? wr_q + tlsg_pkg::QPTR_W'(1) : wr_q;
    rd_d  = pop_ok ? rd_q + tlsg_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + tlsg_pkg::QCNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - tlsg_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/tlsg_stride.sv */
// Stride pipeline: one multiply stage per unrolled part but the innermost, working outward from the innermost part.
module tlsg_stride (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  tlsg_pkg::item_t  head_i,
  output logic             pop_o,
  input  logic             take_i,
  output logic             valid_o,
  output tlsg_pkg::stage_t stg_o
);

  localparam int LAST = tlsg_pkg::NUM_STEPS - 1;

  logic [tlsg_pkg::NUM_STEPS-1:0] vld_q;
  tlsg_pkg::stage_t               stg_q [tlsg_pkg::NUM_STEPS];
  tlsg_pkg::stage_t               src   [tlsg_pkg::NUM_STEPS];
  tlsg_pkg::stage_t               nxt   [tlsg_pkg::NUM_STEPS];
  logic [tlsg_pkg::SIZE_W-1:0]    fac   [tlsg_pkg::NUM_STEPS];
  logic                           adv;

  assign adv     = !vld_q[LAST] || take_i;
  assign pop_o   = adv && head_valid_i;
  assign valid_o = vld_q[LAST];
  assign stg_o   = stg_q[LAST];

  always_comb begin
    src[0].item = head_i;
    for (int u = 0; u < tlsg_pkg::NUM_UNR; u++) begin
      src[0].s[u] = tlsg_pkg::STRIDE_W'(1);
    end
    for (int k = 1; k < tlsg_pkg::NUM_STEPS; k++) begin
      src[k] = stg_q[k-1];
    end
    for (int k = 0; k < tlsg_pkg::NUM_STEPS; k++) begin
      nxt[k] = src[k];
      fac[k] = (src[k].item.q[tlsg_pkg::NUM_UNR-1-k] == '0) ? tlsg_pkg::SIZE_W'(1)
                                                             : src[k].item.q[tlsg_pkg::NUM_UNR-1-k];
      if (src[k].item.q[tlsg_pkg::NUM_UNR-2-k] == '0) begin
        nxt[k].s[tlsg_pkg::NUM_UNR-2-k] = tlsg_pkg::STRIDE_W'(1);
      end else begin
        nxt[k].s[tlsg_pkg::NUM_UNR-2-k] = src[k].s[tlsg_pkg::NUM_UNR-1-k] *
                                          tlsg_pkg::STRIDE_W'(fac[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[tlsg_pkg::NUM_STEPS-2:0], head_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < tlsg_pkg::NUM_STEPS; k++) begin
        stg_q[k] <= nxt[k];
      end
    end
  end

endmodule

/* hw/rtl/tlsg_emit.sv */
// Result sequencer: one result per dimension, or one error result, into an output register.
module tlsg_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tlsg_pkg::stage_t              stg_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tlsg_pkg::DIM_W-1:0]    dim_index_o,
  output logic [tlsg_pkg::STRIDE_W-1:0] outer_stride_o,
  output logic [tlsg_pkg::STRIDE_W-1:0] inner_stride_o,
  output logic [tlsg_pkg::BLK_W-1:0]    block_size_o,
  output logic                          status_o,
  output logic                          last_o
);

  logic [tlsg_pkg::DIM_W-1:0]    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [tlsg_pkg::DIM_W-1:0]    dim_q, dim_d;
  logic [tlsg_pkg::STRIDE_W-1:0] outer_q, outer_d;
  logic [tlsg_pkg::STRIDE_W-1:0] inner_q, inner_d;
  logic [tlsg_pkg::BLK_W-1:0]    blk_q, blk_d;
  logic                          status_q, status_d;
  logic                          last_q, last_d;
  logic                          is_last;
  logic                          load;

  assign is_last = stg_i.item.err || (cnt_q == stg_i.item.n_last);
  assign load    = valid_i && (!out_valid_q || !out_stall_i);
  assign take_o  = load && is_last;

  always_comb begin
    cnt_d       = load ? (is_last ? '0 : cnt_q + tlsg_pkg::DIM_W'(1)) : cnt_q;
    out_valid_d = load || (out_valid_q && out_stall_i);
    status_d    = stg_i.item.err ? tlsg_pkg::STATUS_INVALID : tlsg_pkg::STATUS_OK;
    last_d      = is_last;
    if (stg_i.item.err) begin
      dim_d   = '0;
      outer_d = '0;
      inner_d = '0;
      blk_d   = tlsg_pkg::BLK_W'(1);
    end else begin
      dim_d   = cnt_q;
      outer_d = stg_i.s[stg_i.item.pos_outer[cnt_q]];
      inner_d = stg_i.s[stg_i.item.pos_inner[cnt_q]];
      blk_d   = stg_i.item.blk8[cnt_q] ? tlsg_pkg::BLK_W'(tlsg_pkg::BLOCK_LEN)
                                       : tlsg_pkg::BLK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dim_q    <= dim_d;
      outer_q  <= outer_d;
      inner_q  <= inner_d;
      blk_q    <= blk_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dim_index_o    = dim_q;
  assign outer_stride_o = outer_q;
  assign inner_stride_o = inner_q;
  assign block_size_o   = blk_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> valid_i)
    else $error("stage released without a request");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stg_i.item.err) |-> (cnt_q <= stg_i.item.n_last))
    else $error("dimension counter past the last dimension");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == tlsg_pkg::STATUS_INVALID) |-> (last_o && dim_index_o == '0))
    else $error("error result not a single result");

  a_block_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (block_size_o == tlsg_pkg::BLK_W'(1) ||
                     block_size_o == tlsg_pkg::BLK_W'(tlsg_pkg::BLOCK_LEN)))
    else $error("block size neither one nor a full block");

endmodule

/* hw/rtl/tensor_layout_stride_generator.sv */
// Top level of the tensor layout stride generator.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one tensor descriptor per request:
//   format code, dimension count and five dimension sizes. Output channel
//   (out_valid_o / out_stall_i) returns one request per dimension with the outer
//   stride, inner stride and block size, last_o on the final one, or a single
//   request with status_o set when the descriptor is invalid.
//   Path: a taken descriptor passes the queue, the nine multiply stages and the
//   output register before its first result appears; the rest follow one per
//   cycle while out_stall_i is low. The output sequencer has a single result
//   port, so the results of one descriptor leave one after another.
//   Descriptors enter back to back; a two-entry queue and the nine-stage stride
//   pipeline hold work in flight.
//   Stall: a stalled result holds in the output register, the pipeline stops,
//   the queue fills and in_stall_o rises.
//   Reset: all valid bits and counters clear; nothing is in flight afterward.
module tensor_layout_stride_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tlsg_pkg::FMT_W-1:0]    format_i,
  input  logic [tlsg_pkg::CNT_W-1:0]    dim_count_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_a_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_b_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_c_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_d_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_e_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tlsg_pkg::DIM_W-1:0]    dim_index_o,
  output logic [tlsg_pkg::STRIDE_W-1:0] outer_stride_o,
  output logic [tlsg_pkg::STRIDE_W-1:0] inner_stride_o,
  output logic [tlsg_pkg::BLK_W-1:0]    block_size_o,
  output logic                          status_o,
  output logic                          last_o
);

  tlsg_pkg::item_t  cls_item;
  tlsg_pkg::item_t  head_item;
  tlsg_pkg::stage_t back_stg;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             back_valid;
  logic             back_take;

  assign in_stall_o = q_full;

  tlsg_front u_front (
    .format_i    (format_i),
    .dim_count_i (dim_count_i),
    .size_a_i    (size_a_i),
    .size_b_i    (size_b_i),
    .size_c_i    (size_c_i),
    .size_d_i    (size_d_i),
    .size_e_i    (size_e_i),
    .item_o      (cls_item)
  );

  tlsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (cls_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tlsg_stride u_stride (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_item),
    .pop_o        (q_pop),
    .take_i       (back_take),
    .valid_o      (back_valid),
    .stg_o        (back_stg)
  );

  tlsg_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (back_valid),
    .stg_i          (back_stg),
    .take_o         (back_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dim_index_o    (dim_index_o),
    .outer_stride_o (outer_stride_o),
    .inner_stride_o (inner_stride_o),
    .block_size_o   (block_size_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

/* tb/tlsg_tb_pkg.sv */
// Layout codes and per-format layout tables shared by the stride testbench files.
package tlsg_tb_pkg;

  typedef enum logic [3:0] {
    FMT_X          = 4'd0,
    FMT_NC         = 4'd1,
    FMT_NCHW       = 4'd2,
    FMT_NHWC       = 4'd3,
    FMT_NCHW8C     = 4'd4,
    FMT_OI         = 4'd5,
    FMT_OIHW       = 4'd6,
    FMT_OIHW8I8O   = 4'd7,
    FMT_OHWI8O     = 4'd8,
    FMT_GOIHW      = 4'd9,
    FMT_GOIHW8I8O  = 4'd10,
    FMT_UNKNOWN_LO = 4'd11,
    FMT_UNKNOWN_HI = 4'd15
  } fmt_e;

  // perm lists unrolled parts outermost first; n of zero marks an unknown code.
  typedef struct packed {
    logic [3:0]       n;
    logic [0:4][3:0]  blk;
    logic [0:9][3:0]  perm;
  } layout_t;

  function automatic layout_t layout_of(logic [3:0] code);
    layout_t lay;
    lay.n    = 4'd0;
    lay.blk  = 20'h11111;
    lay.perm = '0;
    case (code)
      FMT_X: begin
        lay.n = 4'd1; lay.perm = 40'h0100000000;
      end
      FMT_NC, FMT_OI: begin
        lay.n = 4'd2; lay.perm = 40'h0123000000;
      end
      FMT_NCHW, FMT_OIHW: begin
        lay.n = 4'd4; lay.perm = 40'h0123456700;
      end
      FMT_NHWC: begin
        lay.n = 4'd4; lay.perm = 40'h0231456700;
      end
      FMT_NCHW8C: begin
        lay.n = 4'd4; lay.blk = 20'h18111; lay.perm = 40'h0123456700;
      end
      FMT_OIHW8I8O: begin
        lay.n = 4'd4; lay.blk = 20'h88111; lay.perm = 40'h0123546700;
      end
      FMT_OHWI8O: begin
        lay.n = 4'd4; lay.blk = 20'h81111; lay.perm = 40'h0231456700;
      end
      FMT_GOIHW: begin
        lay.n = 4'd5; lay.perm = 40'h0123456789;
      end
      FMT_GOIHW8I8O: begin
        lay.n = 4'd5; lay.blk = 20'h18811; lay.perm = 40'h0123457689;
      end
      default: begin
        lay.n = 4'd0;
      end
    endcase
    return lay;
  endfunction

endpackage

/* tb/tensor_layout_stride_checker.sv */
// Channel monitor that predicts per-dimension strides and compares every result.
module tensor_layout_stride_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [tlsg_pkg::FMT_W-1:0]    format_i,
  input  logic [tlsg_pkg::CNT_W-1:0]    dim_count_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_a_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_b_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_c_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_d_i,
  input  logic [tlsg_pkg::SIZE_W-1:0]   size_e_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [tlsg_pkg::DIM_W-1:0]    dim_index_o,
  input  logic [tlsg_pkg::STRIDE_W-1:0] outer_stride_o,
  input  logic [tlsg_pkg::STRIDE_W-1:0] inner_stride_o,
  input  logic [tlsg_pkg::BLK_W-1:0]    block_size_o,
  input  logic                          status_o,
  input  logic                          last_o,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count,
  output int                            reject_count
);
  import tlsg_pkg::*;
  import tlsg_tb_pkg::*;

  typedef struct packed {
    logic [DIM_W-1:0]    dim;
    logic [STRIDE_W-1:0] outer;
    logic [STRIDE_W-1:0] inner;
    logic [BLK_W-1:0]    blk;
    logic                status;
    logic                last;
  } stride_result_t;

  stride_result_t stride_q[$];
  int errors;
  int results;
  int rejects;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void predict_strides(logic [3:0] fmt, logic [3:0] cnt,
                                          logic [4:0][SIZE_W-1:0] sz);
    layout_t             lay;
    logic [STRIDE_W-1:0] part [10];
    logic [STRIDE_W-1:0] st [10];
    logic [STRIDE_W-1:0] ps;
    stride_result_t      r;
    int                  n;
    int                  m;
    int                  prev;
    int                  cur;
    lay = layout_of(fmt);
    n   = int'(lay.n);
    if (n == 0 || cnt != n || n > MAX_DIMS) begin
      r.dim    = '0;
      r.outer  = '0;
      r.inner  = '0;
      r.blk    = BLK_W'(1);
      r.status = STATUS_INVALID;
      r.last   = 1'b1;
      stride_q.push_back(r);
      rejects++;
      return;
    end
    for (int d = 0; d < n; d++) begin
      part[d]     = sz[d] / lay.blk[d];
      part[n + d] = STRIDE_W'(lay.blk[d]);
    end
    m = 2 * n;
    for (int d = 0; d < m; d++) st[d] = STRIDE_W'(1);
    // build strides from the innermost unrolled part outward
    for (int k = 1; k < m; k++) begin
      prev    = int'(lay.perm[m - k]);
      cur     = int'(lay.perm[m - 1 - k]);
      ps      = (part[prev] == 0) ? STRIDE_W'(1) : part[prev];
      st[cur] = (part[cur] == 0) ? STRIDE_W'(1) : st[prev] * ps;
    end
    for (int d = 0; d < n; d++) begin
      r.dim    = DIM_W'(d);
      r.outer  = st[d];
      r.inner  = st[n + d];
      r.blk    = lay.blk[d];
      r.status = STATUS_OK;
      r.last   = (d == n - 1);
      stride_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    stride_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_strides(format_i, dim_count_i,
                        {size_e_i, size_d_i, size_c_i, size_b_i, size_a_i});
      end
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (stride_q.size() == 0) begin
          report("result with no request pending, dim_index", dim_index_o, 0);
        end else begin
          want = stride_q.pop_front();
          if (dim_index_o !== want.dim) report("dim_index", dim_index_o, want.dim);
          if (outer_stride_o !== want.outer) report("outer_stride", outer_stride_o, want.outer);
          if (inner_stride_o !== want.inner) report("inner_stride", inner_stride_o, want.inner);
          if (block_size_o !== want.blk) report("block_size", block_size_o, want.blk);
          if (status_o !== want.status) report("status", status_o, want.status);
          if (last_o !== want.last) report("last", last_o, want.last);
        end
      end
    end
    fail_count   <= errors;
    pending      <= stride_q.size();
    result_count <= results;
    reject_count <= rejects;
  end

endmodule

/* tb/tensor_layout_stride_generator_test.sv */
// Top-level testbench: drives tensor descriptors into the stride generator and gives the verdict.
module tensor_layout_stride_generator_test;
  import tlsg_pkg::*;
  import tlsg_tb_pkg::*;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [FMT_W-1:0]    format_i       = '0;
  logic [CNT_W-1:0]    dim_count_i    = '0;
  logic [SIZE_W-1:0]   size_a_i       = '0;
  logic [SIZE_W-1:0]   size_b_i       = '0;
  logic [SIZE_W-1:0]   size_c_i       = '0;
  logic [SIZE_W-1:0]   size_d_i       = '0;
  logic [SIZE_W-1:0]   size_e_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [DIM_W-1:0]    dim_index_o;
  logic [STRIDE_W-1:0] outer_stride_o;
  logic [STRIDE_W-1:0] inner_stride_o;
  logic [BLK_W-1:0]    block_size_o;
  logic                status_o;
  logic                last_o;

  int fail_count;
  int pending;
  int result_count;
  int reject_count;
  int sent_count = 0;
  bit calm       = 1'b0;

  tensor_layout_stride_generator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .format_i, .dim_count_i, .size_a_i, .size_b_i, .size_c_i, .size_d_i, .size_e_i,
    .out_valid_o, .out_stall_i, .dim_index_o, .outer_stride_o, .inner_stride_o,
    .block_size_o, .status_o, .last_o
  );

  tensor_layout_stride_checker stride_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .format_i, .dim_count_i, .size_a_i, .size_b_i, .size_c_i, .size_d_i, .size_e_i,
    .out_valid_o, .out_stall_i, .dim_index_o, .outer_stride_o, .inner_stride_o,
    .block_size_o, .status_o, .last_o,
    .fail_count, .pending, .result_count, .reject_count
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 18);
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_descriptor(logic [3:0] fmt, logic [3:0] cnt, logic [SIZE_W-1:0] a,
                                 logic [SIZE_W-1:0] b, logic [SIZE_W-1:0] c,
                                 logic [SIZE_W-1:0] d, logic [SIZE_W-1:0] e);
    // idle with junk on the payload
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i  <= 1'b0;
      format_i    <= FMT_W'($urandom);
      dim_count_i <= CNT_W'($urandom);
      size_a_i    <= SIZE_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    format_i    <= fmt;
    dim_count_i <= cnt;
    size_a_i    <= a;
    size_b_i    <= b;
    size_c_i    <= c;
    size_d_i    <= d;
    size_e_i    <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(1, 16));
      default: return SIZE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin : stimulus
    logic [3:0] fmt;
    int         r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int f = FMT_X; f <= FMT_GOIHW8I8O; f++) begin
      send_descriptor(4'(f), layout_of(4'(f)).n, '1, '1, '1, '1, '1);
    end
    send_descriptor(FMT_NCHW8C, 4, 0, 7, 0, 1, '1);
    send_descriptor(FMT_GOIHW8I8O, 5, 3, 0, 9, 0, 5);
    send_descriptor(FMT_OIHW8I8O, 4, 15, 17, 1, 2, 0);
    send_descriptor(FMT_OHWI8O, 4, 7, 3, 0, 9, 0);
    send_descriptor(FMT_X, 1, 0, 0, 0, 0, 0);
    send_descriptor(FMT_NHWC, 4, 0, 0, 0, 0, 0);
    send_descriptor(FMT_GOIHW, 5, 1, 1, 1, 1, 1);
    send_descriptor(FMT_NC, 2, '1, 1, 0, 0, 0);
    send_descriptor(FMT_UNKNOWN_HI, 0, '1, '1, '1, '1, '1);
    send_descriptor(FMT_UNKNOWN_LO, 4, 8, 8, 8, 8, 8);
    send_descriptor(FMT_NCHW, 0, 5, 5, 5, 5, 5);
    send_descriptor(FMT_NCHW, 5, 5, 5, 5, 5, 5);
    send_descriptor(FMT_X, '1, 9, 0, 0, 0, 0);

    for (int i = 0; i < 206; i++) begin
      calm = (i >= 90 && i < 130);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        fmt = 4'($urandom_range(FMT_X, FMT_GOIHW8I8O));
        send_descriptor(fmt, layout_of(fmt).n, pick_size(), pick_size(), pick_size(),
                        pick_size(), pick_size());
      end else if (r < 88) begin
        send_descriptor(4'($urandom_range(FMT_X, FMT_GOIHW8I8O)), 4'($urandom), pick_size(),
                        pick_size(), pick_size(), pick_size(), pick_size());
      end else begin
        send_descriptor(4'($urandom), 4'($urandom), SIZE_W'($urandom), SIZE_W'($urandom),
                        SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("summary: %0d descriptors sent, %0d rejected, %0d dimension results checked",
             sent_count, reject_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* tensor_layout_stride_generator.f */
hw/rtl/tlsg_pkg.sv
hw/rtl/tlsg_front.sv
hw/rtl/tlsg_fifo.sv
hw/rtl/tlsg_stride.sv
hw/rtl/tlsg_emit.sv
hw/rtl/tensor_layout_stride_generator.sv
tb/tlsg_tb_pkg.sv
tb/tensor_layout_stride_checker.sv
tb/tensor_layout_stride_generator_test.sv
